// ----- hw/rtl/eupa_pkg.sv -----
// ----------------------------------------------------------------------------
// eupa_pkg
// Shared types and constants of the exact unitary product accumulator.
// ----------------------------------------------------------------------------
package eupa_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_FIN,
		ST_RED,
		ST_OUT
	} eupa_state_t;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_MUL  = 1'b1;

	localparam int unsigned N_COEF   = 4;
	localparam int unsigned N_PROD   = 64;
	localparam int unsigned CNT_W    = 6;
	localparam int unsigned PHASE_W  = 3;
	localparam int unsigned GUARD_W  = 6;

endpackage

// ----- hw/rtl/eupa_req_if.sv -----
// ----------------------------------------------------------------------------
// eupa_req_if
// Request channel: load or multiply operand word.
// ----------------------------------------------------------------------------
interface eupa_req_if #(
	parameter int COEF_WIDTH = 32,
	parameter int EXP_WIDTH  = 16
);
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic signed [COEF_WIDTH-1:0] rhs_u_w3;
	logic signed [COEF_WIDTH-1:0] rhs_u_w2;
	logic signed [COEF_WIDTH-1:0] rhs_u_w1;
	logic signed [COEF_WIDTH-1:0] rhs_u_w0;
	logic signed [COEF_WIDTH-1:0] rhs_t_w3;
	logic signed [COEF_WIDTH-1:0] rhs_t_w2;
	logic signed [COEF_WIDTH-1:0] rhs_t_w1;
	logic signed [COEF_WIDTH-1:0] rhs_t_w0;
	logic [2:0]                   rhs_phase;
	logic signed [EXP_WIDTH-1:0]  rhs_denom_exp;

	modport source (output valid, req_type, rhs_u_w3, rhs_u_w2, rhs_u_w1, rhs_u_w0,
		rhs_t_w3, rhs_t_w2, rhs_t_w1, rhs_t_w0, rhs_phase, rhs_denom_exp, input ready);
	modport sink (input valid, req_type, rhs_u_w3, rhs_u_w2, rhs_u_w1, rhs_u_w0,
		rhs_t_w3, rhs_t_w2, rhs_t_w1, rhs_t_w0, rhs_phase, rhs_denom_exp, output ready);
endinterface

// ----- hw/rtl/eupa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// eupa_rsp_if
// Response channel: accumulator word after each request.
// ----------------------------------------------------------------------------
interface eupa_rsp_if #(
	parameter int COEF_WIDTH = 32,
	parameter int EXP_WIDTH  = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] acc_u_w3;
	logic signed [COEF_WIDTH-1:0] acc_u_w2;
	logic signed [COEF_WIDTH-1:0] acc_u_w1;
	logic signed [COEF_WIDTH-1:0] acc_u_w0;
	logic signed [COEF_WIDTH-1:0] acc_t_w3;
	logic signed [COEF_WIDTH-1:0] acc_t_w2;
	logic signed [COEF_WIDTH-1:0] acc_t_w1;
	logic signed [COEF_WIDTH-1:0] acc_t_w0;
	logic [2:0]                   acc_phase;
	logic signed [EXP_WIDTH-1:0]  acc_denom_exp;
	logic                         overflow;

	modport source (output valid, acc_u_w3, acc_u_w2, acc_u_w1, acc_u_w0,
		acc_t_w3, acc_t_w2, acc_t_w1, acc_t_w0, acc_phase, acc_denom_exp, overflow,
		input ready);
	modport sink (input valid, acc_u_w3, acc_u_w2, acc_u_w1, acc_u_w0,
		acc_t_w3, acc_t_w2, acc_t_w1, acc_t_w0, acc_phase, acc_denom_exp, overflow,
		output ready);
endinterface

// ----- hw/rtl/exact_unitary_product_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// exact_unitary_product_accumulator_core
// Running 2x2 unitary over Z[w] with one shared signed multiplier.
// ----------------------------------------------------------------------------
// Load: the request is taken in ST_IDLE and the response is valid in ST_OUT.
// Multiply: 64 products through the shared multiplier, one per cycle, then
//   ST_DRAIN, ST_FIN for the wrap, and ST_RED for the sqrt2 reduction steps
//   before the response is valid in ST_OUT.
// One word at a time; ready is low until the response is taken.
// arst_n clears the accumulator to zero and the sequencer to idle.
module exact_unitary_product_accumulator_core
	import eupa_pkg::*;
#(
	parameter int COEF_WIDTH = 32,
	parameter int EXP_WIDTH  = 16
) (
	input logic       clk,
	input logic       arst_n,
	eupa_req_if.sink   req,
	eupa_rsp_if.source rsp
);
	localparam int ACC_W = 2 * COEF_WIDTH + GUARD_W;

	eupa_state_t state_q, state_d;

	logic signed [COEF_WIDTH-1:0] u_q [N_COEF];
	logic signed [COEF_WIDTH-1:0] t_q [N_COEF];
	logic signed [COEF_WIDTH-1:0] ru_q [N_COEF];
	logic signed [COEF_WIDTH-1:0] rt_q [N_COEF];
	logic [PHASE_W-1:0]           l_q, rl_q;
	logic signed [EXP_WIDTH-1:0]  k_q, rk_q;
	logic                         ovf_q;
	logic [CNT_W-1:0]             cnt_q;
	logic signed [ACC_W-1:0]      zu_q [N_COEF];
	logic signed [ACC_W-1:0]      zt_q [N_COEF];

	logic signed [2*COEF_WIDTH-1:0] prod_s1;
	logic                           vld_s1, neg_s1, zsel_s1;
	logic [1:0]                     e_s1;

	// sequencer decode
	logic [1:0]         grp, ii, jj, pi;
	logic               cj, xt, neg;
	logic [PHASE_W-1:0] ee;
	logic signed [COEF_WIDTH-1:0] mx, my;

	always_comb begin
		grp = cnt_q[5:4];
		ii  = cnt_q[3:2];
		jj  = cnt_q[1:0];
		cj  = grp[0];
		xt  = grp[0] ^ grp[1];
		neg = (grp == 2'd1);
		pi  = cj ? 2'(3'd4 - {1'b0, ii}) : ii;
		ee  = {1'b0, pi} + {1'b0, jj} + (cj ? l_q : 3'd0);
		mx  = xt ? t_q[ii] : u_q[ii];
		my  = cj ? rt_q[jj] : ru_q[jj];
	end

	// reduction step
	function automatic logic signed [COEF_WIDTH-1:0] asr1(input logic signed [COEF_WIDTH-1:0] v);
		return v >>> 1;
	endfunction

	logic signed [COEF_WIDTH-1:0] hu [N_COEF];
	logic signed [COEF_WIDTH-1:0] ht [N_COEF];
	logic u_zero, t_zero, u_div, t_div, can_red;

	always_comb begin
		hu[3] = asr1(u_q[2]) - asr1(u_q[0]);
		hu[2] = asr1(u_q[1]) + asr1(u_q[3]) + COEF_WIDTH'(u_q[1][0]);
		hu[1] = asr1(u_q[2]) + asr1(u_q[0]) + COEF_WIDTH'(u_q[2][0]);
		hu[0] = asr1(u_q[1]) - asr1(u_q[3]);
		ht[3] = asr1(t_q[2]) - asr1(t_q[0]);
		ht[2] = asr1(t_q[1]) + asr1(t_q[3]) + COEF_WIDTH'(t_q[1][0]);
		ht[1] = asr1(t_q[2]) + asr1(t_q[0]) + COEF_WIDTH'(t_q[2][0]);
		ht[0] = asr1(t_q[1]) - asr1(t_q[3]);
		u_zero = (u_q[0] == '0) && (u_q[1] == '0) && (u_q[2] == '0) && (u_q[3] == '0);
		t_zero = (t_q[0] == '0) && (t_q[1] == '0) && (t_q[2] == '0) && (t_q[3] == '0);
		u_div  = (u_q[3][0] == u_q[1][0]) && (u_q[2][0] == u_q[0][0]);
		t_div  = (t_q[3][0] == t_q[1][0]) && (t_q[2][0] == t_q[0][0]);
		can_red = !(u_zero && t_zero) && u_div && t_div;
	end

	// wrap checks
	logic zfit;
	logic signed [EXP_WIDTH:0] ksum;
	logic kovf, kdec_ovf;

	always_comb begin
		zfit = 1'b1;
		for (int n = 0; n < N_COEF; n++) begin
			if (zu_q[n] != ACC_W'(signed'(zu_q[n][COEF_WIDTH-1:0]))) zfit = 1'b0;
			if (zt_q[n] != ACC_W'(signed'(zt_q[n][COEF_WIDTH-1:0]))) zfit = 1'b0;
		end
		ksum     = {k_q[EXP_WIDTH-1], k_q} + {rk_q[EXP_WIDTH-1], rk_q};
		kovf     = ksum[EXP_WIDTH] != ksum[EXP_WIDTH-1];
		kdec_ovf = k_q == {1'b1, {(EXP_WIDTH-1){1'b0}}};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (req.valid) state_d = (req.req_type == REQ_MUL) ? ST_MUL : ST_OUT;
			ST_MUL:   if (cnt_q == CNT_W'(N_PROD - 1)) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   state_d = ST_RED;
			ST_RED:   if (!can_red) state_d = ST_OUT;
			ST_OUT:   if (rsp.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready         = (state_q == ST_IDLE);
		rsp.valid         = (state_q == ST_OUT);
		rsp.acc_u_w3      = u_q[3];
		rsp.acc_u_w2      = u_q[2];
		rsp.acc_u_w1      = u_q[1];
		rsp.acc_u_w0      = u_q[0];
		rsp.acc_t_w3      = t_q[3];
		rsp.acc_t_w2      = t_q[2];
		rsp.acc_t_w1      = t_q[1];
		rsp.acc_t_w0      = t_q[0];
		rsp.acc_phase     = l_q;
		rsp.acc_denom_exp = k_q;
		rsp.overflow      = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			ovf_q   <= 1'b0;
			l_q     <= '0;
			k_q     <= '0;
			for (int n = 0; n < N_COEF; n++) begin
				u_q[n] <= '0;
				t_q[n] <= '0;
			end
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_MUL);
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (req.valid && req.req_type == REQ_LOAD) begin
						u_q[3] <= req.rhs_u_w3; u_q[2] <= req.rhs_u_w2;
						u_q[1] <= req.rhs_u_w1; u_q[0] <= req.rhs_u_w0;
						t_q[3] <= req.rhs_t_w3; t_q[2] <= req.rhs_t_w2;
						t_q[1] <= req.rhs_t_w1; t_q[0] <= req.rhs_t_w0;
						l_q    <= req.rhs_phase;
						k_q    <= req.rhs_denom_exp;
						ovf_q  <= 1'b0;
					end
				end
				ST_MUL: cnt_q <= cnt_q + 1'b1;
				ST_FIN: begin
					for (int n = 0; n < N_COEF; n++) begin
						u_q[n] <= zu_q[n][COEF_WIDTH-1:0];
						t_q[n] <= zt_q[n][COEF_WIDTH-1:0];
					end
					l_q   <= l_q + rl_q;
					k_q   <= ksum[EXP_WIDTH-1:0];
					ovf_q <= !zfit || kovf;
				end
				ST_RED: if (can_red) begin
					u_q   <= hu;
					t_q   <= ht;
					k_q   <= k_q - 1'b1;
					ovf_q <= ovf_q || kdec_ovf;
				end
				default: ;
			endcase
		end
	end

	// operand capture, product stage and column sums
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			ru_q[3] <= req.rhs_u_w3; ru_q[2] <= req.rhs_u_w2;
			ru_q[1] <= req.rhs_u_w1; ru_q[0] <= req.rhs_u_w0;
			rt_q[3] <= req.rhs_t_w3; rt_q[2] <= req.rhs_t_w2;
			rt_q[1] <= req.rhs_t_w1; rt_q[0] <= req.rhs_t_w0;
			rl_q    <= req.rhs_phase;
			rk_q    <= req.rhs_denom_exp;
			for (int n = 0; n < N_COEF; n++) begin
				zu_q[n] <= '0;
				zt_q[n] <= '0;
			end
		end
		prod_s1 <= mx * my;
		neg_s1  <= (cj && ii != 2'd0) ^ ee[2] ^ neg;
		e_s1    <= ee[1:0];
		zsel_s1 <= grp[1];
		if (vld_s1) begin
			if (zsel_s1)
				zt_q[e_s1] <= zt_q[e_s1] + (neg_s1 ? -ACC_W'(prod_s1) : ACC_W'(prod_s1));
			else
				zu_q[e_s1] <= zu_q[e_s1] + (neg_s1 ? -ACC_W'(prod_s1) : ACC_W'(prod_s1));
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (cnt_q == '0 && !rsp.valid))
		else $error("ready while busy");
	a_drain_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (vld_s1 && $past(cnt_q) == CNT_W'(N_PROD - 1)))
		else $error("drain without last product");
	a_load_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == REQ_LOAD) |=> (rsp.valid && !rsp.overflow))
		else $error("load response wrong");
endmodule

// ----- tb/exact_unitary_product_accumulator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_unitary_product_accumulator_core_tb
// Checks the running 2x2 Z[w] unitary accumulator against a predictor. The
// sequence is loads and right multiplies with random and extreme operands,
// including sqrt2-reducible products, wrap cases and the zero matrix. Both
// handshakes idle at random.
// ----------------------------------------------------------------------------
module exact_unitary_product_accumulator_core_tb
	import eupa_pkg::*;
();

	typedef struct packed {
		logic [3:0][31:0] u;
		logic [3:0][31:0] t;
		logic [2:0]       ph;
		logic [15:0]      k;
		logic             ovf;
	} acc_word_t;

	typedef struct packed {
		logic             kind;
		logic [3:0][31:0] u;
		logic [3:0][31:0] t;
		logic [2:0]       ph;
		logic [15:0]      k;
	} op_word_t;

	int errors = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	class unitary_scoreboard;
		logic signed [31:0] u[4], t[4];
		logic [2:0]         ph;
		logic signed [15:0] k;
		acc_word_t          pending[$];

		function new();
			for (int i = 0; i < 4; i++) begin
				u[i] = '0;
				t[i] = '0;
			end
			ph = '0;
			k = '0;
		endfunction

		// z += sgn * (cj ? conj(x) : x) * y * w^sh
		function automatic void ring_mac(ref logic signed [127:0] z[4],
				input logic signed [31:0] x[4], input bit cj,
				input logic signed [31:0] y[4], input int sh, input bit neg);
			int pi, e;
			bit s;
			logic signed [127:0] p;
			for (int i = 0; i < 4; i++) begin
				pi = cj ? ((4 - i) & 3) : i;
				for (int j = 0; j < 4; j++) begin
					e = (pi + j + sh) & 7;
					s = (cj && i != 0) ^ (e >= 4) ^ neg;
					p = 128'(x[i]) * 128'(y[j]);
					z[e & 3] = s ? z[e & 3] - p : z[e & 3] + p;
				end
			end
		endfunction

		function automatic void halve(ref logic signed [31:0] x[4]);
			logic signed [33:0] n[4];
			n[3] = (34'(x[2]) - 34'(x[0])) >>> 1;
			n[2] = (34'(x[1]) + 34'(x[3])) >>> 1;
			n[1] = (34'(x[2]) + 34'(x[0])) >>> 1;
			n[0] = (34'(x[1]) - 34'(x[3])) >>> 1;
			for (int i = 0; i < 4; i++) x[i] = n[i][31:0];
		endfunction

		function automatic bit even_pairs(logic signed [31:0] x[4]);
			return (x[3][0] == x[1][0]) && (x[2][0] == x[0][0]);
		endfunction

		function void note_request(op_word_t w);
			logic signed [31:0] ru[4], rt[4];
			logic signed [127:0] zu[4], zt[4];
			logic signed [16:0] ks;
			acc_word_t r;
			bit ovf = 1'b0;
			for (int i = 0; i < 4; i++) begin
				ru[i] = w.u[i];
				rt[i] = w.t[i];
			end
			if (w.kind == REQ_LOAD) begin
				u = ru;
				t = rt;
				ph = w.ph;
				k = w.k;
			end else begin
				for (int i = 0; i < 4; i++) begin
					zu[i] = '0;
					zt[i] = '0;
				end
				ring_mac(zu, u, 1'b0, ru, 0, 1'b0);
				ring_mac(zu, t, 1'b1, rt, int'(ph), 1'b1);
				ring_mac(zt, t, 1'b0, ru, 0, 1'b0);
				ring_mac(zt, u, 1'b1, rt, int'(ph), 1'b0);
				for (int i = 0; i < 4; i++) begin
					if (zu[i] != 128'(signed'(zu[i][31:0])) ||
							zt[i] != 128'(signed'(zt[i][31:0])))
						ovf = 1'b1;
					u[i] = zu[i][31:0];
					t[i] = zt[i][31:0];
				end
				ph = ph + w.ph;
				ks = 17'(k) + 17'(signed'(w.k));
				if (ks != 17'(signed'(ks[15:0]))) ovf = 1'b1;
				k = ks[15:0];
				while (!((u[0] | u[1] | u[2] | u[3] | t[0] | t[1] | t[2] | t[3]) == 0)
						&& even_pairs(u) && even_pairs(t)) begin
					if (k == 16'sh8000) ovf = 1'b1;
					k = k - 16'sd1;
					halve(u);
					halve(t);
				end
			end
			for (int i = 0; i < 4; i++) begin
				r.u[i] = u[i];
				r.t[i] = t[i];
			end
			r.ph = ph;
			r.k = k;
			r.ovf = ovf;
			pending.push_back(r);
		endfunction

		task check_response(acc_word_t got);
			acc_word_t e;
			if (pending.size() == 0) begin
				report("response with nothing expected");
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (got.u[i] !== e.u[i])
					report($sformatf("u w%0d got %h exp %h", i, got.u[i], e.u[i]));
				if (got.t[i] !== e.t[i])
					report($sformatf("t w%0d got %h exp %h", i, got.t[i], e.t[i]));
			end
			if (got.ph !== e.ph) report($sformatf("phase got %0d exp %0d", got.ph, e.ph));
			if (got.k !== e.k) report($sformatf("denom got %h exp %h", got.k, e.k));
			if (got.ovf !== e.ovf) report($sformatf("overflow got %b exp %b", got.ovf, e.ovf));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   src_idle = 0;
	int   snk_idle = 0;
	unitary_scoreboard sb = new();

	eupa_req_if req();
	eupa_rsp_if rsp();

	exact_unitary_product_accumulator_core dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_LOAD;
		{req.rhs_u_w3, req.rhs_u_w2, req.rhs_u_w1, req.rhs_u_w0} = '0;
		{req.rhs_t_w3, req.rhs_t_w2, req.rhs_t_w1, req.rhs_t_w0} = '0;
		req.rhs_phase = '0;
		req.rhs_denom_exp = '0;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			rsp.ready <= ($urandom_range(99) >= snk_idle);
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_response({rsp.acc_u_w3, rsp.acc_u_w2, rsp.acc_u_w1, rsp.acc_u_w0,
				rsp.acc_t_w3, rsp.acc_t_w2, rsp.acc_t_w1, rsp.acc_t_w0,
				rsp.acc_phase, rsp.acc_denom_exp, rsp.overflow});
	end

	// valid drops between words; the block is busy then
	task automatic send_word(input op_word_t w);
		@(posedge clk);
		while ($urandom_range(99) < src_idle) @(posedge clk);
		req.valid <= 1'b1;
		req.req_type <= w.kind;
		{req.rhs_u_w3, req.rhs_u_w2, req.rhs_u_w1, req.rhs_u_w0} <= w.u;
		{req.rhs_t_w3, req.rhs_t_w2, req.rhs_t_w1, req.rhs_t_w0} <= w.t;
		req.rhs_phase <= w.ph;
		req.rhs_denom_exp <= w.k;
		do @(posedge clk); while (!req.ready);
		sb.note_request(w);
		req.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_coef(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($urandom_range(6)) - 32'd3;
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($urandom_range(200)) - 32'd100;
		endcase
	endfunction

	function automatic op_word_t rand_word(bit kind);
		op_word_t w;
		int mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(3) == 0 ? 0 :
			($urandom_range(5) == 0 ? 2 : 3));
		w.kind = kind;
		for (int i = 0; i < 4; i++) begin
			w.u[i] = pick_coef(mode);
			w.t[i] = pick_coef(mode);
		end
		w.ph = 3'($urandom_range(7));
		w.k = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(8)) - 16'd4;
		return w;
	endfunction

	// word from w^i pieces, u = w^a, t = 0 style constructors
	function automatic op_word_t mk(bit kind, logic [127:0] u, logic [127:0] t,
			logic [2:0] ph, logic [15:0] k);
		op_word_t w;
		w.kind = kind;
		w.u = u;
		w.t = t;
		w.ph = ph;
		w.k = k;
		return w;
	endfunction

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		op_word_t w;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero product, identity, H-like reducible operands, extremes
		send_word(mk(REQ_MUL, '0, '0, 3'd0, 16'd0));
		send_word(mk(REQ_LOAD, {32'd0, 32'd0, 32'd0, 32'd1}, '0, 3'd0, 16'd0));
		send_word(mk(REQ_MUL, {32'd0, 32'd0, 32'd0, 32'd1}, {32'd0, 32'd0, 32'd0, 32'd1},
			3'd4, 16'd1));
		send_word(mk(REQ_MUL, {32'd0, 32'd0, 32'd0, 32'd1}, {32'd0, 32'd0, 32'd0, 32'd1},
			3'd4, 16'd1));
		send_word(mk(REQ_MUL, {32'd0, 32'd0, 32'd1, 32'd0}, '0, 3'd7, 16'd0));
		send_word(mk(REQ_MUL, {32'd2, 32'd0, 32'd2, 32'd0}, {32'd0, 32'd2, 32'd0, 32'd2},
			3'd3, 16'h7fff));
		send_word(mk(REQ_MUL, {32'd0, 32'd0, 32'd0, 32'd4}, '0, 3'd1, 16'h7fff));
		send_word(mk(REQ_LOAD, {32'd0, 32'd0, 32'd0, 32'd8}, '0, 3'd5, 16'h8000));
		send_word(mk(REQ_MUL, {32'd0, 32'd0, 32'd0, 32'd1}, '0, 3'd0, 16'd0));
		send_word(mk(REQ_LOAD, {4{32'h7fffffff}}, {4{32'h80000000}}, 3'd7, 16'h7fff));
		send_word(mk(REQ_MUL, {4{32'h7fffffff}}, {4{32'h80000000}}, 3'd7, 16'h7fff));
		send_word(mk(REQ_LOAD, {4{32'hffffffff}}, {4{32'hffffffff}}, 3'd2, 16'hffff));
		send_word(mk(REQ_MUL, {4{32'h80000000}}, {4{32'h7fffffff}}, 3'd6, 16'h8000));
		send_word(mk(REQ_LOAD, '0, '0, 3'd3, 16'd5));
		send_word(mk(REQ_MUL, {4{32'h55555555}}, {4{32'haaaaaaaa}}, 3'd1, 16'd0));

		for (int ph = 0; ph < 3; ph++) begin
			src_idle = ph == 0 ? 20 : (ph == 1 ? 88 : 0);
			snk_idle = ph == 0 ? 88 : (ph == 1 ? 20 : 0);
			for (int n = 0; n < 330; n++) begin
				if (n % 40 == 0) begin
					w = rand_word(REQ_LOAD);
					if ($urandom_range(1)) begin
						w.u = {32'd0, 32'd0, 32'd0, 32'd1};
						w.t = '0;
					end
					send_word(w);
				end else
					send_word(rand_word($urandom_range(9) != 0));
				if (n == 150) wait_drained();
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/eupa_pkg.sv
hw/rtl/eupa_req_if.sv
hw/rtl/eupa_rsp_if.sv
hw/rtl/exact_unitary_product_accumulator_core.sv
tb/exact_unitary_product_accumulator_core_tb.sv
